@@ src/wcs_pkg.sv @@
// Package for welford_cell_stats: constants, command/error codes, sequencer states.
// No dependencies.
package wcs_pkg;
	localparam int DefMaxTimes = 64;
	localparam int DefMaxVars  = 16;

	localparam logic [0:0] CMD_ADD  = 1'b0;
	localparam logic [0:0] CMD_READ = 1'b1;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_NOTRL = 2'd2;

	localparam logic [0:0] REG_VARS  = 1'b0;
	localparam logic [0:0] REG_TIMES = 1'b1;

	localparam logic [31:0] MIN_RST = 32'h7FFF_FFFF;
	localparam logic [31:0] MAX_RST = 32'h8000_0000;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_RDW, ST_DIV1, ST_MUL, ST_DIV2, ST_WR, ST_OUT
	} wcs_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [15:0] divisor;
	} wcs_div_req_t;
endpackage

@@ src/wcs_if.sv @@
// Valid/ready channel interfaces for welford_cell_stats.
// No dependencies.
interface wcs_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        starts_trial;
	logic [5:0]  time_index;
	logic [3:0]  var_index;
	logic signed [31:0] sample_value;
	modport source (output valid, cmd, starts_trial, time_index, var_index, sample_value,
		input ready);
	modport sink (input valid, cmd, starts_trial, time_index, var_index, sample_value,
		output ready);
endinterface

interface wcs_out_if;
	logic        valid;
	logic        ready;
	logic signed [47:0] mean_value;
	logic [63:0] variance_value;
	logic signed [31:0] minimum_value;
	logic signed [31:0] maximum_value;
	logic [15:0] trials_seen;
	logic [1:0]  error_code;
	modport source (output valid, mean_value, variance_value, minimum_value, maximum_value,
		trials_seen, error_code, input ready);
	modport sink (input valid, mean_value, variance_value, minimum_value, maximum_value,
		trials_seen, error_code, output ready);
endinterface

interface wcs_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [6:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/wcs_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module wcs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ src/wcs_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 16-bit divisor.
// Depends on wcs_pkg.
module wcs_div
	import wcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  wcs_div_req_t req,
	output logic         busy,
	output logic [63:0]  quot
);
	logic [63:0] q_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [6:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], q_q[63]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign busy    = (cnt_q != 7'd0);
	assign quot    = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy) begin
			if (!trial[16]) begin
				rem_q <= trial;
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

@@ src/welford_cell_stats.sv @@
// Top level of welford_cell_stats: running mean/variance/min/max per cell.
// Depends on wcs_pkg, wcs_if, wcs_ram, wcs_div.
//
// Each request takes one cell of a MAX_TIMES x MAX_VARS table. A sample request
// goes through a RAM read, a mean-step pass of the shared restoring divider, a
// 32x32 partial-product multiply, a variance pass of the same divider, write-back
// and the result cycle. While the trial count is one the variance pass is skipped.
// Reads and samples with no trial started skip the divider and multiply, and
// out-of-range requests skip the RAM read too. Input is not ready while a request
// is in progress. After reset a clearing pass writes every cell once while input
// is held off; configuration writes are taken at any time.
module welford_cell_stats
	import wcs_pkg::*;
#(
	parameter int MAX_TIMES = DefMaxTimes,
	parameter int MAX_VARS  = DefMaxVars
) (
	input logic clk,
	input logic arst_n,
	wcs_in_if.sink    in_ch,
	wcs_out_if.source out_ch,
	wcs_cfg_if.sink   cfg
);
	localparam int Cells = MAX_TIMES * MAX_VARS;
	localparam int AW = (Cells > 1) ? $clog2(Cells) : 1;
	localparam int RW = 48 + 64 + 64 + 32 + 32;

	wcs_state_t state_q, state_d;
	logic [4:0] vars_q;
	logic [6:0] times_q;
	logic [15:0] trials_q;
	logic [AW-1:0] clr_q, addr_q;
	logic cmd_q;
	logic signed [31:0] x_q;
	logic signed [47:0] mean_q;
	logic [63:0] m2_q, var_q;
	logic signed [31:0] min_q, max_q;
	logic [1:0] err_q;
	logic signed [48:0] delta_q;
	logic [48:0] dmag_q, rmag_q;
	logic [63:0] acc_q;
	logic acc_ovf_q;
	logic [1:0] mstep_q;
	logic out_valid_q;

	logic we;
	logic [AW-1:0] ram_addr;
	logic [RW-1:0] wdata, rdata;
	wcs_div_req_t dreq;
	logic dbusy;
	logic [63:0] dquot;

	wcs_ram #(.Width(RW), .Depth(Cells)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata));

	wcs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dquot));

	logic [12:0] tlim, vlim;
	logic in_range;
	logic [15:0] trials_next;
	logic signed [48:0] xw;
	logic signed [48:0] delta_rd;
	logic signed [48:0] nm;
	logic signed [48:0] rest;
	logic [31:0] dpart, rpart;
	logic [63:0] pprod;
	logic [63:0] m2_new;

	function automatic logic [63:0] delta_mag(input logic signed [48:0] d);
		logic [48:0] m;
		m = d[48] ? 49'(-d) : d;
		return {15'd0, m};
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	assign tlim = ({6'd0, times_q} < 13'(MAX_TIMES)) ? {6'd0, times_q} : 13'(MAX_TIMES);
	assign vlim = ({8'd0, vars_q} < 13'(MAX_VARS)) ? {8'd0, vars_q} : 13'(MAX_VARS);
	assign in_range = ({7'd0, in_ch.time_index} < tlim) && ({9'd0, in_ch.var_index} < vlim);
	assign trials_next = (in_ch.starts_trial && trials_q != 16'hFFFF) ? trials_q + 16'd1
		: trials_q;
	assign xw = {x_q[31], x_q, 16'd0};
	assign delta_rd = xw - 49'($signed(rdata[RW-1 -: 48]));
	assign nm = delta_q[48] ? (49'(mean_q) - 49'(dquot)) : (49'(mean_q) + 49'(dquot));
	assign rest = xw - nm;

	always_comb begin
		case (mstep_q)
			2'd0: begin dpart = dmag_q[31:0];       rpart = rmag_q[31:0]; end
			2'd1: begin dpart = {15'd0, dmag_q[48:32]}; rpart = rmag_q[31:0]; end
			2'd2: begin dpart = dmag_q[31:0];       rpart = {15'd0, rmag_q[48:32]}; end
			default: begin dpart = {15'd0, dmag_q[48:32]}; rpart = {15'd0, rmag_q[48:32]}; end
		endcase
	end
	assign pprod = {32'd0, dpart} * {32'd0, rpart};
	assign m2_new = sat_add(m2_q, (acc_ovf_q || pprod[63:32] != 32'd0)
		? 64'hFFFF_FFFF_FFFF_FFFF : sat_add(acc_q, {pprod[31:0], 32'd0}));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(Cells - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = in_range ? ST_RD : ST_OUT;
				end
			end
			ST_RD:   state_d = ST_RDW;
			ST_RDW: begin
				if (cmd_q == CMD_ADD && err_q == ERR_OK) state_d = ST_DIV1;
				else state_d = ST_OUT;
			end
			ST_DIV1: if (!dbusy && !dreq.start) state_d = ST_MUL;
			ST_MUL:  if (mstep_q == 2'd3) state_d = ST_DIV2;
			ST_DIV2: if (!dbusy && !dreq.start) state_d = ST_WR;
			ST_WR:   state_d = ST_OUT;
			ST_OUT:  if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		ram_addr = addr_q;
		wdata = {mean_q, m2_q, var_q, min_q, max_q};
		dreq = '{start: 1'b0, dividend: '0, divisor: trials_q};
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				ram_addr = clr_q;
				wdata = {48'd0, 64'd0, 64'd0, MIN_RST, MAX_RST};
			end
			ST_RDW: begin
				if (cmd_q == CMD_ADD && err_q == ERR_OK) begin
					dreq.start = 1'b1;
					dreq.dividend = delta_mag(delta_rd);
				end
			end
			ST_MUL: begin
				if (mstep_q == 2'd3 && trials_q > 16'd1) begin
					dreq.start = 1'b1;
					dreq.dividend = m2_new;
					dreq.divisor = trials_q - 16'd1;
				end
			end
			ST_WR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			vars_q <= 5'd16;
			times_q <= 7'd64;
			trials_q <= '0;
			out_valid_q <= 1'b0;
			mstep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg.valid) begin
				if (cfg.index == REG_VARS) vars_q <= cfg.data[4:0];
				else times_q <= cfg.data;
			end
			if (state_q == ST_IDLE && in_ch.valid) trials_q <= trials_next;
			if (state_q == ST_MUL) mstep_q <= mstep_q + 2'd1;
			else mstep_q <= '0;
			if (state_d == ST_OUT && state_q != ST_OUT) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					cmd_q <= in_ch.cmd;
					x_q <= in_ch.sample_value;
					addr_q <= AW'(32'(in_ch.time_index) * 32'(MAX_VARS)
						+ 32'(in_ch.var_index));
					err_q <= !in_range ? ERR_RANGE
						: (in_ch.cmd == CMD_ADD && trials_next == 16'd0) ? ERR_NOTRL : ERR_OK;
					mean_q <= '0; m2_q <= '0; var_q <= '0; min_q <= '0; max_q <= '0;
				end
			end
			ST_RDW: begin
				{mean_q, m2_q, var_q, min_q, max_q} <= rdata;
				delta_q <= delta_rd;
			end
			ST_DIV1: begin
				if (!dbusy && !dreq.start) begin
					dmag_q <= delta_q[48] ? 49'(-delta_q) : delta_q;
					rmag_q <= rest[48] ? 49'(-rest) : rest;
					mean_q <= nm[47:0];
					acc_q <= '0;
					acc_ovf_q <= 1'b0;
					if (x_q < min_q) min_q <= x_q;
					if (x_q > max_q) max_q <= x_q;
				end
			end
			ST_MUL: begin
				case (mstep_q)
					2'd0: acc_q <= {32'd0, pprod[63:32]};
					2'd1, 2'd2: acc_q <= acc_q + pprod;
					default: begin
						m2_q <= m2_new;
						if (trials_q <= 16'd1) var_q <= '0;
					end
				endcase
			end
			ST_DIV2: if (!dbusy && !dreq.start && trials_q > 16'd1) var_q <= dquot;
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.mean_value = mean_q;
	assign out_ch.variance_value = var_q;
	assign out_ch.minimum_value = min_q;
	assign out_ch.maximum_value = max_q;
	assign out_ch.trials_seen = trials_q;
	assign out_ch.error_code = err_q;
endmodule

@@ src/wcs_checker.sv @@
// Port-level checker for welford_cell_stats, bound to the top level.
// Depends on wcs_pkg.
module wcs_port_checker
	import wcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] error_code,
	input logic [63:0] variance_value
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= ERR_NOTRL) else $error("bad error code");
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_RANGE |-> variance_value == 64'd0)
		else $error("range error with data");
endmodule

bind welford_cell_stats wcs_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .error_code(out_ch.error_code),
	.variance_value(out_ch.variance_value));
